/* rtl/pds_pkg.sv */
package pds_pkg;

	// Microseconds in one second, wide enough for sums that run past it
	localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

	// Configuration register indexes
	localparam logic CFG_INTERVAL_SEC  = 1'b0;
	localparam logic CFG_INTERVAL_USEC = 1'b1;

	// Request payload
	typedef struct packed {
		logic [31:0] now_sec;
		logic [19:0] now_usec;
	} req_t;

	// Response payload
	typedef struct packed {
		logic        status;
		logic        missed;
		logic [31:0] next_sec;
		logic [19:0] next_usec;
		logic [31:0] wait_sec;
		logic [19:0] wait_usec;
	} rsp_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_FIN,
		S_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_now;
		logic eval;
		logic fin;
		logic resp_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic invalid;
		logic miss;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

/* rtl/pds_ifs.sv */
interface pds_req_if import pds_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pds_rsp_if import pds_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/periodic_deadline_scheduler_unit.sv */
// Periodic deadline scheduler. Each request transaction carries the current time; the block
// moves its stored deadline on by the configured interval and answers with the deadline and
// the time left until it. When there is no deadline yet or the moved one already lies in the
// past, the deadline is set anew by rounding the seconds and microseconds up to the next
// multiple of their interval part, and the response is flagged as missed. An interval that
// is zero or has 1000000 microseconds or more gives status 1 and leaves the deadline alone.
// After a request is accepted the controller passes through S_EVAL, S_FIN and S_RESP, where
// the response register is loaded once the previous response has been taken; an invalid
// interval skips S_FIN, and after a miss S_DIV waits for the two bit-per-cycle remainder
// units, of which the 32-bit seconds unit is the longer. The next request can be accepted
// in the cycle after the response register is loaded, while that response still waits there.
module periodic_deadline_scheduler_unit import pds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pds_req_if.sink     req,
	pds_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	pds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Arithmetic, state and response register
	pds_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.rsp_data  (rsp.data),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

endmodule

/* rtl/pds_rdiv.sv */
module pds_rdiv #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] rem,
	output logic         done
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  rem_q;
	logic [W:0]    trial;
	logic [W-1:0]  rem_nxt;

	// Shift in one dividend bit and subtract where the divisor fits
	always_comb begin
		trial = {rem_q, dvd_q[W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_nxt = W'(trial - {1'b0, divisor});
		end else begin
			rem_nxt = trial[W-1:0];
		end
	end

	// Count the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Hold the partial remainder and the unused dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

/* rtl/pds_dpath.sv */
module pds_dpath import pds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  req_t        req_data,
	output rsp_t        rsp_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] isec_q;
	logic [19:0] iusec_q;
	logic [31:0] dl_s_q;
	logic [19:0] dl_u_q;
	logic [31:0] now_s_q;
	logic [19:0] now_u_q;
	logic [31:0] adv_s_q;
	logic [20:0] adv_u_q;
	logic        miss_q;
	logic        inval_q;
	logic [31:0] ds_q;
	logic [19:0] du_q;
	rsp_t        rsp_q;
	logic        out_valid_q;

	logic [31:0] rem_s;
	logic [19:0] rem_u;
	logic        done_s;
	logic        done_u;

	logic        inval;
	logic [31:0] adv_s;
	logic [20:0] adv_u;
	logic        miss;
	logic [31:0] sel_s;
	logic [20:0] sel_u;
	logic        carry_d;
	logic [31:0] ds_nxt;
	logic [20:0] du_nxt;
	logic        gt;
	logic [31:0] ws0;
	logic [20:0] du_up;
	logic [20:0] wu0;
	logic        carry_w;
	logic [31:0] ws;
	logic [20:0] wu;
	rsp_t        rsp_nxt;

	// Remainders of the current time by each interval part
	pds_rdiv #(.W(32)) u_div_sec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load_now),
		.dividend (req_data.now_sec),
		.divisor  (isec_q),
		.rem      (rem_s),
		.done     (done_s)
	);

	pds_rdiv #(.W(20)) u_div_usec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load_now),
		.dividend (req_data.now_usec),
		.divisor  (iusec_q),
		.rem      (rem_u),
		.done     (done_u)
	);

	// Check the interval, advance a set deadline by one period and detect a miss
	always_comb begin
		inval = ((isec_q == '0) && (iusec_q == '0)) || ({1'b0, iusec_q} >= USEC_PER_SEC);
		if (dl_s_q != '0) begin
			adv_s = dl_s_q + isec_q;
			adv_u = {1'b0, dl_u_q} + {1'b0, iusec_q};
		end else begin
			adv_s = dl_s_q;
			adv_u = {1'b0, dl_u_q};
		end
		miss = (adv_s == '0) || (adv_s < now_s_q) ||
		       ((adv_s == now_s_q) && (adv_u < {1'b0, now_u_q}));
	end

	// Take the advanced deadline, or round up to the next multiple after a miss, then carry into seconds
	always_comb begin
		if (!miss_q) begin
			sel_s = adv_s_q;
		end else if (isec_q != '0) begin
			sel_s = now_s_q - rem_s + isec_q;
		end else begin
			sel_s = now_s_q;
		end
		if (!miss_q) begin
			sel_u = adv_u_q;
		end else if (iusec_q != '0) begin
			sel_u = {1'b0, now_u_q} - {1'b0, rem_u} + {1'b0, iusec_q};
		end else begin
			sel_u = '0;
		end
		carry_d = (sel_u >= USEC_PER_SEC);
		ds_nxt  = sel_s + {31'd0, carry_d};
		du_nxt  = carry_d ? (sel_u - USEC_PER_SEC) : sel_u;
	end

	// Time left until the deadline
	always_comb begin
		gt    = (ds_q > now_s_q);
		du_up = {1'b0, du_q} + USEC_PER_SEC;
		if (gt) begin
			ws0 = ds_q - now_s_q - 32'd1;
			wu0 = (du_up >= {1'b0, now_u_q}) ? (du_up - {1'b0, now_u_q}) : '0;
		end else begin
			ws0 = '0;
			wu0 = (du_q >= now_u_q) ? {1'b0, du_q - now_u_q} : '0;
		end
		carry_w = (wu0 >= USEC_PER_SEC);
		ws      = ws0 + {31'd0, carry_w};
		wu      = carry_w ? (wu0 - USEC_PER_SEC) : wu0;

		rsp_nxt = '0;
		if (inval_q) begin
			rsp_nxt.status = 1'b1;
		end else begin
			rsp_nxt.missed    = miss_q;
			rsp_nxt.next_sec  = ds_q;
			rsp_nxt.next_usec = du_q;
			rsp_nxt.wait_sec  = ws;
			rsp_nxt.wait_usec = wu[19:0];
		end
	end

	// Configuration and deadline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isec_q  <= 32'd1;
			iusec_q <= '0;
			dl_s_q  <= '0;
			dl_u_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_INTERVAL_SEC:  isec_q  <= cfg_wdata;
					CFG_INTERVAL_USEC: iusec_q <= cfg_wdata[19:0];
					default:           ;
				endcase
			end
			if (cmd.fin) begin
				dl_s_q <= ds_nxt;
				dl_u_q <= du_nxt[19:0];
			end
		end
	end

	// Output register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current transaction
	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			now_s_q <= req_data.now_sec;
			now_u_q <= req_data.now_usec;
		end
		if (cmd.eval) begin
			adv_s_q <= adv_s;
			adv_u_q <= adv_u;
			miss_q  <= miss;
			inval_q <= inval;
		end
		if (cmd.fin) begin
			ds_q <= ds_nxt;
			du_q <= du_nxt[19:0];
		end
		if (cmd.resp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign sts.invalid  = inval;
	assign sts.miss     = miss;
	assign sts.div_done = done_s && done_u;
	assign sts.out_busy = out_valid_q && !rsp_ready;

	assign rsp_data  = rsp_q;
	assign rsp_valid = out_valid_q;

endmodule

/* rtl/pds_ctrl.sv */
module pds_ctrl import pds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_nxt;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				priority if (sts.invalid) begin
					state_nxt = S_RESP;
				end else if (sts.miss) begin
					state_nxt = S_DIV;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_now = req_valid;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
			end
			S_DIV: begin
			end
			S_FIN: begin
				cmd.fin = 1'b1;
			end
			S_RESP: begin
				cmd.resp_load = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
